// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("check failed");
`else
`define CHK_IMPLY(label, clk, rst_n, a, c)
`define CHK_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/hbac_pkg.sv =====
// ----------------------------------------------------------------------------
// hbac_pkg
// Shared opcodes, status codes, sizes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package hbac_pkg;
	// arena and table sizes
	localparam int ARENA_BYTES = 64;
	localparam int MAX_BLOCKS  = 16;

	localparam logic [2:0] OP_ALLOC   = 3'd0;
	localparam logic [2:0] OP_REALLOC = 3'd1;
	localparam logic [2:0] OP_FREE    = 3'd2;
	localparam logic [2:0] OP_DEFRAG  = 3'd3;
	localparam logic [2:0] OP_RESET   = 3'd4;
	localparam logic [2:0] OP_WRITE   = 3'd5;
	localparam logic [2:0] OP_READ    = 3'd6;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOSPACE = 3'd1;
	localparam logic [2:0] ST_UNKNOWN = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_OFFSET  = 3'd4;

	// datapath command code
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,     // capture input item, start table scan
		CMD_SCAN,      // one table entry per cycle
		CMD_COPY,      // copy one arena byte
		CMD_ZERO,      // zero one arena byte (free tail, clear)
		CMD_COMMIT,    // update table and result
		CMD_DF_PICK,   // scan for lowest id not yet moved
		CMD_DF_MOVE,   // move one byte of the chosen block
		CMD_SNAP,      // copy arena to scratch and clear it
		CMD_RDWR       // byte access
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t cmd;
	} hbac_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic copy_done;
		logic pick_found;
		logic pick_done;
		logic [2:0] op;
		logic fail;
	} hbac_stat_t;
endpackage

// ===== rtl/handle_bump_allocator_compacting.sv =====
// ----------------------------------------------------------------------------
// handle_bump_allocator_compacting
// Handle-keyed bump allocator over a byte arena with compaction.
// ----------------------------------------------------------------------------
// Usage: one request item enters on s_axis (opcode, handle, size, offset,
// data); exactly one result item leaves on m_axis. One item is in work at a
// time. Every item first scans the 16-entry table; alloc, failed requests
// and the unused opcode then finish, and the next item is taken only after
// its result has been loaded. Byte read and write then access one arena
// byte. Free zeroes the bytes of the block and reset zeroes the whole arena.
// Realloc copies the kept bytes, each read and then written, to the bump
// pointer and then zeroes the old block. Defragment snapshots the arena into
// scratch and clears it, then repeats a table pass for the lowest id not yet
// moved and moves that block down, and at last zeroes the tail.
// After reset the table is cleared at once and the arena is cleared with
// s_axis_tready low. A stalled receiver holds the result in the output
// register; a finished item then waits until the register frees.
`include "assert_macros.svh"
module handle_bump_allocator_compacting (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode[2:0], handle_in[34:3], request_size[41:35], byte_offset[47:42],
	// write_byte[55:48]
	input  logic [55:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// status[2:0], handle_out[34:3], block_address[40:35], block_size[47:41],
	// read_byte[55:48]
	output logic [55:0] m_axis_tdata
);
	import hbac_pkg::*;

	hbac_cmd_t cmd;
	hbac_stat_t stat;
	logic busy, result_load, in_go, out_free;
	logic [2:0] st;
	logic [31:0] ho;
	logic [5:0] ba;
	logic [6:0] bs;
	logic [7:0] rb;
	logic [55:0] out_q;
	logic ovalid_q;

	assign s_axis_tready = !busy;
	assign in_go = s_axis_tvalid && !busy;
	assign out_free = !ovalid_q || m_axis_tready;

	hbac_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go), .out_free(out_free),
		.stat(stat), .cmd(cmd), .busy(busy), .result_load(result_load)
	);

	hbac_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.opcode(s_axis_tdata[2:0]), .handle_in(s_axis_tdata[34:3]),
		.request_size(s_axis_tdata[41:35]), .byte_offset(s_axis_tdata[47:42]),
		.write_byte(s_axis_tdata[55:48]), .stat(stat),
		.status(st), .handle_out(ho), .block_address(ba), .block_size(bs),
		.read_byte(rb)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (result_load) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (result_load) out_q <= {rb, bs, ba, ho, st};
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = out_q;

	`CHK_IMPLY(a_no_overwrite, clk, arst_n, ovalid_q && !m_axis_tready, !result_load)
	`CHK_IMPLY(a_ready_idle, clk, arst_n, s_axis_tready, !busy)
	`CHK_NEXT(a_load_valid, clk, arst_n, result_load, m_axis_tvalid)
endmodule

// ===== rtl/hbac_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbac_ctrl
// Sequencer: drives the datapath through scan, copy, zero, snapshot, pick, move, byte access and commit phases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hbac_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_go,
	input  logic out_free,
	input  hbac_pkg::hbac_stat_t stat,
	output hbac_pkg::hbac_cmd_t cmd,
	output logic busy,
	output logic result_load
);
	import hbac_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_COPY, S_ZERO, S_PICK, S_MOVE, S_DONE, S_CLR, S_SNAP, S_RDWR
	} state_t;

	state_t state_q;

	assign busy = (state_q != S_IDLE);

	// command decode
	always_comb begin
		cmd.cmd = CMD_NONE;
		result_load = 1'b0;
		case (state_q)
			S_IDLE: if (in_go) cmd.cmd = CMD_LATCH;
			S_SCAN: cmd.cmd = CMD_SCAN;
			S_COPY: cmd.cmd = CMD_COPY;
			S_ZERO: cmd.cmd = CMD_ZERO;
			S_CLR: cmd.cmd = CMD_ZERO;
			S_SNAP: cmd.cmd = CMD_SNAP;
			S_PICK: cmd.cmd = CMD_DF_PICK;
			S_MOVE: cmd.cmd = CMD_DF_MOVE;
			S_RDWR: cmd.cmd = CMD_RDWR;
			S_DONE: begin
				if (out_free) begin
					cmd.cmd = CMD_COMMIT;
					result_load = 1'b1;
				end
			end
			default: cmd.cmd = CMD_NONE;
		endcase
	end

	// state register; arena clearing pass right after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			case (state_q)
				S_IDLE: if (in_go) begin
					state_q <= S_SCAN;
				end
				S_SCAN: if (stat.scan_done) begin
					if (stat.fail) state_q <= S_DONE;
					else if (stat.op == OP_REALLOC) state_q <= S_COPY;
					else if (stat.op == OP_FREE || stat.op == OP_RESET) state_q <= S_ZERO;
					else if (stat.op == OP_DEFRAG) state_q <= S_SNAP;
					else if (stat.op == OP_WRITE || stat.op == OP_READ) state_q <= S_RDWR;
					else state_q <= S_DONE;
				end
				S_COPY: if (stat.copy_done) begin
					state_q <= S_ZERO;
				end
				S_ZERO: if (stat.copy_done) begin
					state_q <= S_DONE;
				end
				S_CLR: if (stat.copy_done) begin
					state_q <= S_IDLE;
				end
				S_SNAP: if (stat.copy_done) begin
					state_q <= S_PICK;
				end
				S_RDWR: if (stat.copy_done) begin
					state_q <= S_DONE;
				end
				S_PICK: if (stat.pick_done) begin
					if (stat.pick_found) state_q <= S_MOVE;
					else state_q <= S_ZERO;
				end
				S_MOVE: if (stat.copy_done) begin
					state_q <= S_PICK;
				end
				S_DONE: if (out_free) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`CHK_IMPLY(a_go_idle, clk, arst_n, cmd.cmd == CMD_LATCH, state_q == S_IDLE)
	`CHK_NEXT(a_latch_scan, clk, arst_n, cmd.cmd == CMD_LATCH, state_q == S_SCAN)
	`CHK_IMPLY(a_load_done, clk, arst_n, result_load, state_q == S_DONE && out_free)
endmodule

// ===== rtl/hbac_dp.sv =====
// ----------------------------------------------------------------------------
// hbac_dp
// Datapath: arena memory, block table, scan and byte move engines.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hbac_dp (
	input  logic clk,
	input  logic arst_n,
	input  hbac_pkg::hbac_cmd_t cmd,
	input  logic [2:0]  opcode,
	input  logic [31:0] handle_in,
	input  logic [6:0]  request_size,
	input  logic [5:0]  byte_offset,
	input  logic [7:0]  write_byte,
	output hbac_pkg::hbac_stat_t stat,
	output logic [2:0]  status,
	output logic [31:0] handle_out,
	output logic [5:0]  block_address,
	output logic [6:0]  block_size,
	output logic [7:0]  read_byte
);
	import hbac_pkg::*;

	localparam int AW = $clog2(ARENA_BYTES);
	localparam int EW = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;
	localparam int PW = AW + 1;
	localparam logic [PW-1:0] ARENA_N = PW'(ARENA_BYTES);

	// arena memory, registered read
	logic [7:0] arena_q [ARENA_BYTES];
	logic       mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [7:0] mem_wd, mem_rd_q;

	always_ff @(posedge clk) begin
		if (mem_we) arena_q[mem_wa] <= mem_wd;
		mem_rd_q <= arena_q[mem_ra];
	end

	// block table
	logic [31:0] ent_id_q   [MAX_BLOCKS];
	logic [PW-1:0] ent_off_q [MAX_BLOCKS];
	logic [6:0]  ent_size_q [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] ent_valid_q, done_q;
	logic [PW-1:0] bump_q;
	logic [31:0] next_id_q;

	// latched item
	logic [2:0]  op_q;
	logic [31:0] h_q;
	logic [6:0]  sz_q;
	logic [5:0]  boff_q;
	logic [7:0]  wb_q;

	// scan state
	logic [EW:0] idx_q;
	logic        hit_q, fr_q, nosp_q;
	logic [EW-1:0] hit_e_q, fr_e_q, best_q;
	logic        best_ok_q;
	logic [PW-1:0] cnt_q, pos_q, zero_hi_q;
	logic        rd_pend_q;
	logic        fail_q;
	logic [2:0]  st_q;
	logic [7:0]  rd_q;

	logic [EW-1:0] ix;
	logic [PW-1:0] src_a, dst_a, copy_n, eoff, acc;
	logic [6:0] esz, copy_len;
	logic       dec_fail;
	logic [2:0] dec_st;

	assign ix   = idx_q[EW-1:0];
	assign eoff = ent_off_q[hit_e_q];
	assign esz  = ent_size_q[hit_e_q];
	assign copy_len = (esz < sz_q) ? esz : sz_q;
	assign acc  = eoff + PW'(boff_q);

	// defragment scratch copy of the arena, registered read
	logic [7:0] scratch_q [ARENA_BYTES];
	logic [7:0] scr_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.cmd == CMD_SNAP && rd_pend_q) scratch_q[cnt_q[AW-1:0]] <= mem_rd_q;
		scr_rd_q <= scratch_q[src_a[AW-1:0]];
	end

	// move engine addresses
	always_comb begin
		src_a = '0;
		dst_a = '0;
		copy_n = '0;
		case (cmd.cmd)
			CMD_COPY: begin
				src_a = eoff + cnt_q;
				dst_a = bump_q + cnt_q;
				copy_n = PW'(copy_len);
			end
			CMD_DF_MOVE: begin
				src_a = ent_off_q[best_q] + cnt_q;
				dst_a = pos_q + cnt_q;
				copy_n = PW'(ent_size_q[best_q]);
			end
			CMD_SNAP: begin
				src_a = cnt_q;
				dst_a = cnt_q;
				copy_n = ARENA_N;
			end
			default: ;
		endcase
	end

	// memory port control; copy, move and snapshot take a read phase then a write phase per byte
	always_comb begin
		mem_we = 1'b0;
		mem_wa = dst_a[AW-1:0];
		mem_wd = mem_rd_q;
		mem_ra = src_a[AW-1:0];
		case (cmd.cmd)
			CMD_COPY: begin
				mem_we = rd_pend_q && cnt_q < copy_n && src_a < ARENA_N && dst_a < ARENA_N;
			end
			CMD_DF_MOVE: begin
				mem_we = rd_pend_q && cnt_q < copy_n && src_a < ARENA_N && dst_a < ARENA_N;
				mem_wd = scr_rd_q;
			end
			CMD_SNAP: begin
				mem_we = rd_pend_q && cnt_q < copy_n;
				mem_wd = 8'd0;
			end
			CMD_ZERO: begin
				mem_we = cnt_q < zero_hi_q && cnt_q < ARENA_N;
				mem_wa = cnt_q[AW-1:0];
				mem_wd = 8'd0;
			end
			CMD_RDWR: begin
				mem_ra = acc[AW-1:0];
				mem_wa = acc[AW-1:0];
				mem_wd = wb_q;
				mem_we = (op_q == OP_WRITE) && !rd_pend_q;
			end
			default: ;
		endcase
	end

	// outcome of the table scan
	always_comb begin
		dec_fail = 1'b0;
		dec_st = ST_OK;
		case (op_q)
			OP_ALLOC: begin
				if (nosp_q) begin dec_fail = 1'b1; dec_st = ST_NOSPACE; end
				else if (!fr_q) begin dec_fail = 1'b1; dec_st = ST_FULL; end
			end
			OP_REALLOC: begin
				if (nosp_q) begin dec_fail = 1'b1; dec_st = ST_NOSPACE; end
				else if (!hit_q) begin dec_fail = 1'b1; dec_st = ST_UNKNOWN; end
				else if (!fr_q) begin dec_fail = 1'b1; dec_st = ST_FULL; end
			end
			OP_FREE: begin
				if (!hit_q) begin dec_fail = 1'b1; dec_st = ST_UNKNOWN; end
			end
			OP_WRITE, OP_READ: begin
				if (!hit_q) begin dec_fail = 1'b1; dec_st = ST_UNKNOWN; end
				else if (PW'(boff_q) >= PW'(esz) || acc >= ARENA_N) begin
					dec_fail = 1'b1; dec_st = ST_OFFSET;
				end
			end
			default: ;
		endcase
	end

	// status to controller
	always_comb begin
		stat.op = op_q;
		stat.fail = dec_fail;
		stat.scan_done = (idx_q == (EW+1)'(MAX_BLOCKS));
		stat.copy_done = 1'b0;
		case (cmd.cmd)
			CMD_COPY, CMD_DF_MOVE, CMD_SNAP:
				stat.copy_done = rd_pend_q && (cnt_q + 1'b1 >= copy_n);
			CMD_ZERO: stat.copy_done = (cnt_q + 1'b1 >= zero_hi_q) || (cnt_q + 1'b1 >= ARENA_N);
			CMD_RDWR: stat.copy_done = rd_pend_q;
			default: ;
		endcase
		if ((cmd.cmd == CMD_COPY || cmd.cmd == CMD_DF_MOVE) && copy_n == '0)
			stat.copy_done = 1'b1;
		stat.pick_done = (idx_q == (EW+1)'(MAX_BLOCKS));
		stat.pick_found = best_ok_q;
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_valid_q <= '0;
			done_q <= '0;
			bump_q <= '0;
			next_id_q <= 32'd1;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			cnt_q <= '0;
			zero_hi_q <= ARENA_N;
			op_q <= '0;
			h_q <= '0;
			sz_q <= '0;
			boff_q <= '0;
			wb_q <= '0;
			hit_q <= 1'b0;
			fr_q <= 1'b0;
			nosp_q <= 1'b0;
			hit_e_q <= '0;
			fr_e_q <= '0;
			best_q <= '0;
			best_ok_q <= 1'b0;
			pos_q <= '0;
			fail_q <= 1'b0;
			st_q <= ST_OK;
			rd_q <= '0;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				ent_id_q[i] <= '0;
				ent_off_q[i] <= '0;
				ent_size_q[i] <= '0;
			end
		end else begin
			case (cmd.cmd)
				CMD_LATCH: begin
					op_q <= opcode;
					h_q <= handle_in;
					sz_q <= request_size;
					boff_q <= byte_offset;
					wb_q <= write_byte;
					idx_q <= '0;
					hit_q <= 1'b0;
					fr_q <= 1'b0;
					hit_e_q <= '0;
					fr_e_q <= '0;
					nosp_q <= ({1'b0, bump_q} + {1'b0, PW'(request_size)}) >= {1'b0, ARENA_N};
					fail_q <= 1'b0;
					st_q <= ST_OK;
					rd_q <= '0;
					cnt_q <= '0;
					rd_pend_q <= 1'b0;
					pos_q <= '0;
					done_q <= '0;
					zero_hi_q <= '0;
					best_ok_q <= 1'b0;
				end
				CMD_SCAN: begin
					if (!stat.scan_done) begin
						idx_q <= idx_q + 1'b1;
						if (!hit_q && ent_valid_q[ix] && ent_id_q[ix] == h_q) begin
							hit_q <= 1'b1;
							hit_e_q <= ix;
						end
						if (!fr_q && !ent_valid_q[ix]) begin
							fr_q <= 1'b1;
							fr_e_q <= ix;
						end
					end else begin
						// decide outcome
						idx_q <= '0;
						cnt_q <= '0;
						fail_q <= dec_fail;
						st_q <= dec_st;
						case (op_q)
							OP_REALLOC: begin
								zero_hi_q <= eoff + PW'(esz);
							end
							OP_FREE: begin
								zero_hi_q <= eoff + PW'(esz);
								cnt_q <= eoff;
							end
							OP_RESET: begin
								zero_hi_q <= ARENA_N;
								ent_valid_q <= '0;
								bump_q <= '0;
								for (int i = 0; i < MAX_BLOCKS; i++) begin
									ent_id_q[i] <= '0;
									ent_off_q[i] <= '0;
									ent_size_q[i] <= '0;
								end
							end
							default: ;
						endcase
					end
				end
				CMD_COPY, CMD_DF_MOVE, CMD_SNAP: begin
					if (copy_n == '0) begin
						cnt_q <= '0;
					end else if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q + 1'b1 >= copy_n) cnt_q <= '0;
					end
					if (cmd.cmd == CMD_DF_MOVE && stat.copy_done) begin
						ent_off_q[best_q] <= pos_q;
						pos_q <= pos_q + PW'(ent_size_q[best_q]);
						done_q[best_q] <= 1'b1;
					end
					if (cmd.cmd == CMD_COPY && stat.copy_done) cnt_q <= eoff;
				end
				CMD_ZERO: begin
					cnt_q <= cnt_q + 1'b1;
				end
				CMD_RDWR: begin
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						rd_q <= mem_rd_q;
					end
				end
				CMD_DF_PICK: begin
					if (!stat.pick_done) begin
						idx_q <= idx_q + 1'b1;
						if (ent_valid_q[ix] && !done_q[ix] &&
						    (!best_ok_q || ent_id_q[ix] < ent_id_q[best_q])) begin
							best_ok_q <= 1'b1;
							best_q <= ix;
						end
					end else begin
						idx_q <= '0;
						cnt_q <= '0;
						rd_pend_q <= 1'b0;
						if (!best_ok_q) begin
							// all placed: zero the tail
							bump_q <= pos_q;
							cnt_q <= pos_q;
							zero_hi_q <= ARENA_N;
						end else begin
							best_ok_q <= 1'b0;
						end
					end
				end
				CMD_COMMIT: begin
					if (!fail_q) begin
						case (op_q)
							OP_ALLOC, OP_REALLOC: begin
								ent_valid_q[fr_e_q] <= 1'b1;
								ent_id_q[fr_e_q] <= next_id_q;
								ent_off_q[fr_e_q] <= bump_q;
								ent_size_q[fr_e_q] <= sz_q;
								bump_q <= bump_q + PW'(sz_q);
								next_id_q <= (next_id_q == '1) ? 32'd1 : next_id_q + 1'b1;
								if (op_q == OP_REALLOC) begin
									ent_valid_q[hit_e_q] <= 1'b0;
									ent_id_q[hit_e_q] <= '0;
									ent_off_q[hit_e_q] <= '0;
									ent_size_q[hit_e_q] <= '0;
								end
							end
							OP_FREE: begin
								ent_valid_q[hit_e_q] <= 1'b0;
								ent_id_q[hit_e_q] <= '0;
								ent_off_q[hit_e_q] <= '0;
								ent_size_q[hit_e_q] <= '0;
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// result fields
	always_comb begin
		status = st_q;
		handle_out = '0;
		block_address = '0;
		block_size = '0;
		read_byte = '0;
		if (!fail_q && (op_q == OP_ALLOC || op_q == OP_REALLOC)) begin
			handle_out = next_id_q;
			block_address = 6'(bump_q);
			block_size = sz_q;
		end
		if (!fail_q && op_q == OP_READ) read_byte = rd_q;
	end

	`CHK_IMPLY(a_ptr_range, clk, arst_n, 1'b1, bump_q < ARENA_N)
	`CHK_IMPLY(a_id_nonzero, clk, arst_n, 1'b1, next_id_q != 32'd0)
	`CHK_NEXT(a_reset_clears, clk, arst_n, cmd.cmd == CMD_SCAN && stat.scan_done && op_q == OP_RESET, ent_valid_q == '0)
endmodule
